### hw/rtl/rectangle_fill_cell_store_assert.svh
// Assertion macros for the rectangle fill cell store.
// Both macros check on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef RECTANGLE_FILL_CELL_STORE_ASSERT_SVH
`define RECTANGLE_FILL_CELL_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RFCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RFCS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);
`else
`define RFCS_ASSERT(name, prop, msg)
`define RFCS_ASSERT_IMPL(name, ante, cons, msg)
`endif

`endif

### hw/rtl/rfcs_pkg.sv
package rfcs_pkg;

  localparam int unsigned MAX_ROWS = 128;
  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned CELL_CNT = MAX_ROWS * MAX_COLS;
  localparam int unsigned CELL_AW  = (CELL_CNT > 1) ? $clog2(CELL_CNT) : 1;

  localparam int unsigned COORD_W  = 7;
  localparam int unsigned DATA_W   = 32;
  // Wide enough to compare a coordinate against the largest supported dimension.
  localparam int unsigned CMP_W    = 11;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_AW-1:0] cell_addr_t;
  typedef logic [DATA_W-1:0]  cell_data_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_FILL = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef struct packed {
    coord_t     first_row;
    coord_t     first_col;
    coord_t     last_row;
    coord_t     last_col;
    cell_data_t value;
  } fill_cmd_t;

  typedef struct packed {
    logic       en;
    cell_addr_t addr;
    cell_data_t data;
  } wr_req_t;

  function automatic logic row_in_store(coord_t row);
    return CMP_W'(row) < CMP_W'(MAX_ROWS);
  endfunction

  function automatic logic col_in_store(coord_t col);
    return CMP_W'(col) < CMP_W'(MAX_COLS);
  endfunction

  function automatic cell_addr_t cell_addr(coord_t row, coord_t col);
    return CELL_AW'(CELL_AW'(row) * CELL_AW'(MAX_COLS) + CELL_AW'(col));
  endfunction

endpackage

### hw/rtl/rectangle_fill_cell_store.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   mode, first/last row and column, cell_value
// out      output     out_valid_o / out_stall_i read_value
//
// A load writes the memory when accepted. A read goes through the registered memory port;
// a further read waits for the first to reach the output register.
// A fill writes the cells of its clipped rectangle one at a time through the
// single memory write port; input is stalled while it walks.
// Reset clears control state only; cell contents are undefined until written.
// Loads and fills are taken while a read result waits in the output register.
`include "rectangle_fill_cell_store_assert.svh"

module rectangle_fill_cell_store import rfcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [6:0]         first_row_i,
  input  logic [6:0]         first_col_i,
  input  logic [6:0]         last_row_i,
  input  logic [6:0]         last_col_i,
  input  logic signed [31:0] cell_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o
);

  logic       walk_busy;
  wr_req_t    walk_wr;
  fill_cmd_t  fill_cmd;
  logic       rd_block;
  logic       rd_pend;
  logic       is_load;
  logic       is_fill;
  logic       is_read;
  logic       accept;
  logic       in_store;
  logic       load_we;
  logic       rd_issue;
  cell_addr_t in_addr;
  cell_data_t ram_rdata;
  cell_data_t out_data;
  logic       mem_we;
  cell_addr_t mem_waddr;
  cell_data_t mem_wdata;

  assign is_load  = (mode_i == MODE_LOAD);
  assign is_fill  = (mode_i == MODE_FILL);
  assign is_read  = (mode_i == MODE_READ);

  assign in_stall_o = walk_busy || (is_read && rd_block);
  assign accept     = in_valid_i && !in_stall_o;

  assign in_store = row_in_store(first_row_i) && col_in_store(first_col_i);
  assign in_addr  = cell_addr(first_row_i, first_col_i);
  assign load_we  = accept && is_load && in_store;
  assign rd_issue = accept && is_read;

  assign fill_cmd.first_row = first_row_i;
  assign fill_cmd.first_col = first_col_i;
  assign fill_cmd.last_row  = last_row_i;
  assign fill_cmd.last_col  = last_col_i;
  assign fill_cmd.value     = cell_value_i;

  rfcs_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && is_fill),
    .cmd_i   (fill_cmd),
    .busy_o  (walk_busy),
    .wr_o    (walk_wr)
  );

  // Loads arrive only while the walker is idle, so the two never share a cycle.
  assign mem_we    = load_we || walk_wr.en;
  assign mem_waddr = walk_wr.en ? walk_wr.addr : in_addr;
  assign mem_wdata = walk_wr.en ? walk_wr.data : cell_value_i;

  rfcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_CNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_issue && in_store),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  rfcs_rdout u_rdout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (rd_issue),
    .zero_i      (!in_store),
    .rdata_i     (ram_rdata),
    .out_stall_i (out_stall_i),
    .block_o     (rd_block),
    .pend_o      (rd_pend),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign read_value_o = out_data;

  `RFCS_ASSERT_IMPL(a_walk_stalls_input, walk_busy, in_stall_o, "input taken during a fill")
  `RFCS_ASSERT_IMPL(a_pend_finds_room, rd_pend, !out_valid_o, "read data has no free slot")
  `RFCS_ASSERT(a_one_writer, !(load_we && walk_wr.en), "load and fill write together")
  `RFCS_ASSERT_IMPL(a_read_lands, rd_issue, ##1 rd_pend ##1 out_valid_o, "read result lost")

endmodule

### hw/rtl/rfcs_ram.sv
module rfcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the entry written in the same cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rfcs_walk.sv
module rfcs_walk import rfcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  fill_cmd_t cmd_i,
  output logic      busy_o,
  output wr_req_t   wr_o
);

  typedef enum logic [1:0] {
    WS_IDLE = 2'b01,
    WS_WALK = 2'b10
  } walk_state_e;

  walk_state_e state_q, state_d;
  coord_t      row_q, row_d;
  coord_t      col_q, col_d;
  coord_t      first_col_q, first_col_d;
  coord_t      last_row_q, last_row_d;
  coord_t      last_col_q, last_col_d;
  cell_data_t  value_q, value_d;
  coord_t      clip_row;
  coord_t      clip_col;
  logic        nonempty;

  // Clip the far corner to the store; a start corner outside it leaves the
  // clipped rectangle empty.
  always_comb begin
    clip_row = cmd_i.last_row;
    clip_col = cmd_i.last_col;
    if (CMP_W'(cmd_i.last_row) >= CMP_W'(MAX_ROWS)) begin
      clip_row = COORD_W'(MAX_ROWS - 1);
    end
    if (CMP_W'(cmd_i.last_col) >= CMP_W'(MAX_COLS)) begin
      clip_col = COORD_W'(MAX_COLS - 1);
    end
    nonempty = (cmd_i.first_row <= clip_row) && (cmd_i.first_col <= clip_col);
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    first_col_d = first_col_q;
    last_row_d  = last_row_q;
    last_col_d  = last_col_q;
    value_d     = value_q;
    unique case (state_q)
      WS_IDLE: begin
        if (start_i && nonempty) begin
          state_d     = WS_WALK;
          row_d       = cmd_i.first_row;
          col_d       = cmd_i.first_col;
          first_col_d = cmd_i.first_col;
          last_row_d  = clip_row;
          last_col_d  = clip_col;
          value_d     = cmd_i.value;
        end
      end
      WS_WALK: begin
        if (col_q == last_col_q) begin
          col_d = first_col_q;
          if (row_q == last_row_q) begin
            state_d = WS_IDLE;
          end else begin
            row_d = row_q + COORD_W'(1);
          end
        end else begin
          col_d = col_q + COORD_W'(1);
        end
      end
      default: state_d = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    first_col_q <= first_col_d;
    last_row_q  <= last_row_d;
    last_col_q  <= last_col_d;
    value_q     <= value_d;
  end

  assign busy_o   = (state_q == WS_WALK);
  assign wr_o.en   = (state_q == WS_WALK);
  assign wr_o.addr = cell_addr(row_q, col_q);
  assign wr_o.data = value_q;

endmodule

### hw/rtl/rfcs_rdout.sv
module rfcs_rdout import rfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       issue_i,
  input  logic       zero_i,
  input  cell_data_t rdata_i,
  input  logic       out_stall_i,
  output logic       block_o,
  output logic       pend_o,
  output logic       out_valid_o,
  output cell_data_t out_data_o
);

  logic       pend_q, pend_d;
  logic       zero_q;
  logic       out_valid_q, out_valid_d;
  cell_data_t out_data_q, out_data_d;

  always_comb begin
    pend_d      = issue_i;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    // The output register is always free by the time the memory data arrives.
    if (pend_q) begin
      out_valid_d = 1'b1;
      out_data_d  = zero_q ? '0 : rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (issue_i) begin
      zero_q <= zero_i;
    end
  end

  // A new read may start only if its data will find the output register empty.
  assign block_o     = pend_q || (out_valid_q && out_stall_i);
  assign pend_o      = pend_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sim/rectangle_fill_cell_store_tb.sv
module rectangle_fill_cell_store_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfcs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT    = 100000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AFTER  = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 700;
  localparam int COORD_MAX      = 127;

  typedef struct {
    logic [1:0] mode;
    coord_t     first_row;
    coord_t     first_col;
    coord_t     last_row;
    coord_t     last_col;
    cell_data_t value;
  } blit_item_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i       = '0;
  logic [6:0]         first_row_i  = '0;
  logic [6:0]         first_col_i  = '0;
  logic [6:0]         last_row_i   = '0;
  logic [6:0]         last_col_i   = '0;
  logic signed [31:0] cell_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic signed [31:0] read_value_o;

  rectangle_fill_cell_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .first_row_i  (first_row_i),
    .first_col_i  (first_col_i),
    .last_row_i   (last_row_i),
    .last_col_i   (last_col_i),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus side: items waiting to be offered and the cells that items queued so far will write.
  blit_item_t blit_queue[$];
  bit         cell_written [CELL_CNT];

  // Predictor side: the store as the block should hold it and the reads still owed.
  cell_data_t grid [CELL_CNT];
  cell_data_t read_values_due[$];

  int n_loads, n_fills, n_reads, n_ignored, n_cells_filled;
  int inputs_taken;
  int results_seen;
  int mismatches;
  int stall_during_hold;

  function automatic void queue_blit(logic [1:0] mode, int r0, int c0, int r1, int c1,
                                     cell_data_t v);
    blit_item_t it;
    it.mode      = mode;
    it.first_row = coord_t'(r0);
    it.first_col = coord_t'(c0);
    it.last_row  = coord_t'(r1);
    it.last_col  = coord_t'(c1);
    it.value     = v;
    blit_queue = {blit_queue, it};
    if (mode == MODE_LOAD) begin
      cell_written[r0 * MAX_COLS + c0] = 1'b1;
    end else if (mode == MODE_FILL) begin
      for (int r = r0; r <= r1; r++)
        for (int c = c0; c <= c1; c++)
          cell_written[r * MAX_COLS + c] = 1'b1;
    end
  endfunction

  // Applies one accepted transfer to the predicted store.
  function automatic void apply_blit(blit_item_t it);
    int r0, c0, r1, c1;
    r0 = it.first_row;
    c0 = it.first_col;
    r1 = it.last_row;
    c1 = it.last_col;
    case (it.mode)
      MODE_LOAD: begin
        grid[r0 * MAX_COLS + c0] = it.value;
        n_loads++;
      end
      MODE_FILL: begin
        n_fills++;
        if (r0 <= r1 && c0 <= c1) begin
          for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
              grid[r * MAX_COLS + c] = it.value;
          n_cells_filled += (r1 - r0 + 1) * (c1 - c0 + 1);
        end
      end
      MODE_READ: begin
        read_values_due = {read_values_due, grid[r0 * MAX_COLS + c0]};
        n_reads++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  blit_item_t cur_item;
  bit         in_taken;
  int         burst_left;
  int         gap_left;
  int         gap_kind;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        apply_blit(cur_item);
        inputs_taken <= inputs_taken + 1;
      end
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (blit_queue.size() > 0) begin
          cur_item = blit_queue.pop_front();
          mode_i       <= cur_item.mode;
          first_row_i  <= cur_item.first_row;
          first_col_i  <= cur_item.first_col;
          last_row_i   <= cur_item.last_row;
          last_col_i   <= cur_item.last_col;
          cell_value_i <= cur_item.value;
          in_valid_i   <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_kind   = $urandom_range(0, 9);
            if (gap_kind < 4) gap_left = 0;
            else if (gap_kind < 9) gap_left = $urandom_range(1, 4);
            else gap_left = $urandom_range(10, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a changing stall pattern, plus one long hold-off once traffic is under way.
  int  hold_left;
  bit  hold_done;
  int  stall_pattern;
  int  pattern_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
      pattern_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
      if (in_valid_i && in_stall_o) stall_during_hold++;
    end else if (!hold_done && inputs_taken >= HOLDOFF_AFTER) begin
      hold_done   = 1'b1;
      hold_left   = HOLDOFF_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_pattern = $urandom_range(0, 3);
        pattern_left  = $urandom_range(32, 256);
      end else begin
        pattern_left--;
      end
      case (stall_pattern)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= !out_stall_i;
      endcase
    end
  end

  // Read results are checked in order against the predicted values.
  cell_data_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (read_values_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("read result %h arrived with no read outstanding", read_value_o);
      end else begin
        want = read_values_due.pop_front();
        if (read_value_o !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("read_value mismatch: expected %h (%0d), got %h (%0d)",
                     want, $signed(want), read_value_o, read_value_o);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int counted, kind, h, w, r, c, r1, c1;
    int rect_r0, rect_c0, rect_r1, rect_c1;

    // Corners and value extremes before the store is fully written.
    queue_blit(MODE_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF);
    queue_blit(MODE_LOAD, COORD_MAX, COORD_MAX, 0, 0, 32'h8000_0000);
    queue_blit(MODE_READ, 0, 0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    queue_blit(MODE_READ, COORD_MAX, COORD_MAX, 0, 0, 32'h0);
    queue_blit(MODE_LOAD, 0, COORD_MAX, COORD_MAX, 0, 32'hFFFF_FFFF);
    queue_blit(MODE_READ, 0, COORD_MAX, 0, 0, $urandom);
    queue_blit(MODE_LOAD, COORD_MAX, 0, 0, COORD_MAX, 32'h0);
    queue_blit(MODE_READ, COORD_MAX, 0, 0, 0, $urandom);
    // Whole store, so every later read hits a written cell.
    queue_blit(MODE_FILL, 0, 0, COORD_MAX, COORD_MAX, 32'h5A5A_A5A5);
    queue_blit(MODE_READ, 64, 64, 0, 0, $urandom);
    queue_blit(MODE_READ, COORD_MAX, COORD_MAX, 0, 0, $urandom);
    // A rectangle that is empty by rows, then one empty by columns, must leave cells alone.
    queue_blit(MODE_FILL, 10, 5, 9, 20, 32'h1111_1111);
    queue_blit(MODE_READ, 10, 5, 0, 0, $urandom);
    queue_blit(MODE_FILL, 5, 10, 20, 9, 32'h2222_2222);
    queue_blit(MODE_READ, 5, 10, 0, 0, $urandom);
    queue_blit(MODE_FILL, 3, 3, 3, 3, 32'h8000_0000);
    queue_blit(MODE_READ, 3, 3, 0, 0, $urandom);
    queue_blit(MODE_FILL, COORD_MAX, 0, COORD_MAX, COORD_MAX, 32'h7FFF_FFFF);
    queue_blit(MODE_READ, COORD_MAX, 77, 0, 0, $urandom);
    queue_blit(MODE_FILL, 0, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    queue_blit(MODE_READ, 40, COORD_MAX, 0, 0, $urandom);
    // The unused mode must neither write nor answer.
    queue_blit(MODE_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    queue_blit(MODE_READ, 0, 0, 0, 0, $urandom);

    rect_r0 = 0; rect_c0 = 0; rect_r1 = 0; rect_c1 = 0;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        queue_blit(MODE_LOAD, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), $urandom);
        counted++;
      end else if (kind < 55) begin
        // Mostly small rectangles; a fill writes its cells one at a time.
        if ($urandom_range(0, 9) != 0) begin
          h = $urandom_range(1, 8);
          w = $urandom_range(1, 8);
        end else begin
          h = $urandom_range(1, 32);
          w = $urandom_range(1, 32);
        end
        r  = $urandom_range(0, COORD_MAX);
        c  = $urandom_range(0, COORD_MAX);
        r1 = (r + h - 1 > COORD_MAX) ? COORD_MAX : r + h - 1;
        c1 = (c + w - 1 > COORD_MAX) ? COORD_MAX : c + w - 1;
        queue_blit(MODE_FILL, r, c, r1, c1, $urandom);
        rect_r0 = r; rect_c0 = c; rect_r1 = r1; rect_c1 = c1;
        counted++;
      end else if (kind < 58) begin
        r = $urandom_range(1, COORD_MAX);
        c = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 1) != 0)
          queue_blit(MODE_FILL, r, c, $urandom_range(0, r - 1), $urandom_range(0, COORD_MAX),
                     $urandom);
        else
          queue_blit(MODE_FILL, c, r, $urandom_range(0, COORD_MAX), $urandom_range(0, r - 1),
                     $urandom);
      end else if (kind < 60) begin
        queue_blit(MODE_UNUSED, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), $urandom);
      end else begin
        // Half the reads land inside the most recent rectangle.
        if ($urandom_range(0, 1) != 0) begin
          r = $urandom_range(rect_r0, rect_r1);
          c = $urandom_range(rect_c0, rect_c1);
        end else begin
          r = $urandom_range(0, COORD_MAX);
          c = $urandom_range(0, COORD_MAX);
        end
        while (!cell_written[r * MAX_COLS + c]) begin
          r = $urandom_range(0, COORD_MAX);
          c = $urandom_range(0, COORD_MAX);
        end
        queue_blit(MODE_READ, r, c, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom);
        counted++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (blit_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (read_values_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Ran %0d loads, %0d fills covering %0d cells, %0d reads (%0d results), %0d unused.",
             n_loads, n_fills, n_cells_filled, n_reads, results_seen, n_ignored);
    $display("Input stalled %0d cycles during the long output hold-off; %0d mismatches.",
             stall_during_hold, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
